### rtl/mean_square_level_bargraph_top_macros.svh
// Assertion macros used by the mean-square level meter top level.
`ifndef MEAN_SQUARE_LEVEL_BARGRAPH_TOP_MACROS_SVH
`define MEAN_SQUARE_LEVEL_BARGRAPH_TOP_MACROS_SVH

// Check on every clock edge outside reset.
`define MSL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check on every clock edge, reset included.
`define MSL_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/msl_pkg.sv
// Shared constants, types and functions of the mean-square level meter.
`timescale 1ns / 1ps
package msl_pkg;

  localparam int unsigned WINDOW_DEF = 1024;

  localparam int unsigned SAMPLE_W = 11;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 11'd1279;
  localparam int unsigned SQ_W = 21;
  localparam int unsigned MEAN_W = 21;
  localparam int unsigned STEP_W = 20;
  localparam int unsigned MULT_W = 23;
  localparam int unsigned BAND_W = 4;
  localparam int unsigned LED_W = 9;
  localparam int unsigned BAND_COUNT = 8;
  localparam logic [STEP_W-1:0] STEP_RESET = 20'd131072;

  // Mean square handed from the window stage to the grading stage.
  typedef struct packed {
    logic              valid;
    logic [MEAN_W-1:0] mean;
  } mean_req_t;

  // Thermometer bar for a band; bands five to eight share the full bar.
  function automatic logic [LED_W-1:0] led_of_band(input logic [BAND_W-1:0] b);
    logic [LED_W-1:0] led;
    case (b)
      4'd1:                      led = 9'b000000001;
      4'd2:                      led = 9'b000000011;
      4'd3:                      led = 9'b000000111;
      4'd4:                      led = 9'b000001111;
      4'd5, 4'd6, 4'd7, 4'd8:    led = 9'b000011111;
      default:                   led = '0;
    endcase
    return led;
  endfunction

endpackage

### rtl/msl_window.sv
// Ring store of squared samples and running window sum.
`timescale 1ns / 1ps
module msl_window #(
  parameter int unsigned WINDOW = msl_pkg::WINDOW_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          take,
  input  logic [msl_pkg::SAMPLE_W-1:0]  sample,
  input  logic                          adv2,
  output logic                          busy,
  output msl_pkg::mean_req_t            win
);
  import msl_pkg::*;

  localparam int unsigned PTR_W = $clog2(WINDOW);
  localparam int unsigned SUM_W = SQ_W + PTR_W;

  logic [SQ_W-1:0]     mem [WINDOW];
  logic [SQ_W-1:0]     rd_data;
  logic [PTR_W-1:0]    ptr;
  logic                wrapped;
  logic [SAMPLE_W-1:0] sat;
  logic [SQ_W-1:0]     sq;
  logic                s1_valid;
  logic                s1_old_ok;
  logic [SQ_W-1:0]     s1_sq;
  logic                s1_adv;
  logic [SQ_W-1:0]     old;
  logic [SUM_W-1:0]    sum;
  logic [SUM_W-1:0]    sum_next;
  logic                s2_valid;
  logic [MEAN_W-1:0]   s2_mean;

  always_comb begin
    sat = (sample > SAMPLE_MAX) ? SAMPLE_MAX : sample;
    sq  = SQ_W'(SQ_W'(sat) * SQ_W'(sat));
  end

  // Read the oldest square and overwrite it in the same cycle.
  always_ff @(posedge clk) begin
    if (take) begin
      rd_data   <= mem[ptr];
      mem[ptr]  <= sq;
      s1_sq     <= sq;
      s1_old_ok <= wrapped;
    end
  end

  // Entries not yet written since reset read as zero until the pointer wraps.
  assign old      = s1_old_ok ? rd_data : '0;
  assign sum_next = sum - SUM_W'(old) + SUM_W'(s1_sq);
  assign s1_adv   = !s2_valid || adv2;
  assign busy     = s1_valid && !s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr      <= '0;
      wrapped  <= 1'b0;
      s1_valid <= 1'b0;
      sum      <= '0;
      s2_valid <= 1'b0;
    end else begin
      if (take) begin
        ptr <= ptr + 1'b1;
        if (ptr == PTR_W'(WINDOW - 1)) begin
          wrapped <= 1'b1;
        end
      end
      if (take) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_valid && s1_adv) begin
        sum <= sum_next;
      end
      if (s1_adv) begin
        s2_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_adv) begin
      s2_mean <= sum_next[SUM_W-1:PTR_W];
    end
  end

  assign win.valid = s2_valid;
  assign win.mean  = s2_mean;

endmodule

### rtl/mean_square_level_bargraph_top.sv
// Top level of the mean-square level meter with bar-graph output.
`timescale 1ns / 1ps
`include "mean_square_level_bargraph_top_macros.svh"
// Usage:
//   Input channel (in_valid, in_stall, sample) carries one unsigned ADC sample
//   per request. Output channel (out_valid, out_stall, mean_square, band,
//   led_pattern, over_range) returns one result per sample, in order.
//   The config channel (cfg_valid, cfg_ready, level_step) sets the band width;
//   write it only while the meter is idle. cfg_ready is always high.
// Pipeline: the accepting edge registers the store read and the square; then
//   the sum stage registers the mean, and grading loads the result register.
// Throughput: one sample per cycle while in_stall is low; the single-port
//   ring store is read and overwritten at the same address as a sample is taken.
// Reset: synchronous; empties the pipeline, zeroes the window sum and the
//   ring pointer, and restores the band width to unsigned integer 131072. Store
//   entries not written since reset read as zero until the pointer first wraps,
//   so the mean ramps up over the first WINDOW samples with no clearing pass.
// Stall: a stalled result holds on the output; the stages behind it keep
//   taking samples until they are full, then in_stall rises.
module mean_square_level_bargraph_top #(
  parameter int unsigned WINDOW = msl_pkg::WINDOW_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [msl_pkg::SAMPLE_W-1:0]  sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [msl_pkg::MEAN_W-1:0]    mean_square,
  output logic [msl_pkg::BAND_W-1:0]    band,
  output logic [msl_pkg::LED_W-1:0]     led_pattern,
  output logic                          over_range,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [msl_pkg::STEP_W-1:0]    level_step
);
  import msl_pkg::*;

  logic              take;
  logic              adv2;
  logic              busy;
  mean_req_t         win;
  logic [MULT_W-1:0] step_mult [BAND_COUNT];
  logic [BAND_COUNT-1:0] le;
  logic [BAND_W-1:0] band_c;

  assign cfg_ready = 1'b1;
  assign in_stall  = busy;
  assign take      = in_valid && !in_stall;
  assign adv2      = !out_valid || !out_stall;

  msl_window #(
    .WINDOW (WINDOW)
  ) u_window (
    .clk    (clk),
    .rst    (rst),
    .take   (take),
    .sample (sample),
    .adv2   (adv2),
    .busy   (busy),
    .win    (win)
  );

  // Hold the band limits as multiples of the step, refreshed on each write.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < BAND_COUNT; i++) begin
        step_mult[i] <= MULT_W'(MULT_W'(STEP_RESET) * MULT_W'(i + 1));
      end
    end else if (cfg_valid && cfg_ready) begin
      for (int i = 0; i < BAND_COUNT; i++) begin
        step_mult[i] <= MULT_W'(MULT_W'(level_step) * MULT_W'(i + 1));
      end
    end
  end

  // Lowest band whose limit reaches the mean; zero when none does.
  always_comb begin
    band_c = '0;
    for (int i = 0; i < BAND_COUNT; i++) begin
      le[i] = (MULT_W'(win.mean) <= step_mult[i]);
    end
    for (int i = BAND_COUNT - 1; i >= 0; i--) begin
      if (le[i]) begin
        band_c = BAND_W'(i + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv2) begin
      out_valid <= win.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && win.valid) begin
      mean_square <= win.mean;
      band        <= band_c;
      led_pattern <= led_of_band(band_c);
      over_range  <= (band_c == '0);
    end
  end

  `MSL_ASSERT(a_over_band, out_valid |-> (over_range == (band == '0)), "over flag mismatch")
  `MSL_ASSERT(a_led_lit, (out_valid && !over_range) |-> (led_pattern != '0), "dark bar in range")
  `MSL_ASSERT(a_band_max, out_valid |-> (band <= BAND_W'(BAND_COUNT)), "band above top band")
  `MSL_ASSERT(a_stall_full, in_stall |-> (win.valid && out_valid && out_stall), "stall with room")
  `MSL_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "result present after reset")

endmodule

### tb/mean_square_level_bargraph_top_test.sv
// Self-checking testbench for the mean-square level meter with bar-graph output.
`timescale 1ns / 1ps
module mean_square_level_bargraph_top_test;
  import msl_pkg::*;

  localparam int unsigned WIN         = WINDOW_DEF;
  localparam int unsigned WIN_SHIFT   = $clog2(WIN);
  localparam int unsigned RAMP_BANDS  = 4;
  localparam logic [LED_W-1:0] FULL_BAR = 9'h01F;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PHASES      = 10;
  localparam int unsigned PHASE_ITEMS = 110;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned IDLE_PCT    = 38;
  localparam int unsigned SHOWN_ERRS  = 10;

  typedef struct packed {
    logic [MEAN_W-1:0] mean;
    logic [BAND_W-1:0] band;
    logic [LED_W-1:0]  led;
    logic              over;
  } reading_t;

  // Tracks the meter's window and holds the readings still owed by the block.
  class level_scoreboard;
    logic [SQ_W-1:0]   squares [WIN];
    logic [30:0]       window_total;
    int unsigned       slot;
    logic [STEP_W-1:0] step;
    reading_t          readings_due[$];
    int unsigned       mismatches;

    function new();
      foreach (squares[i]) squares[i] = '0;
      window_total = '0;
      slot = 0;
      step = STEP_RESET;
      mismatches = 0;
    endfunction

    function void set_step(input logic [STEP_W-1:0] v);
      step = v;
    endfunction

    function logic [MEAN_W-1:0] mean_now();
      return MEAN_W'(window_total >> WIN_SHIFT);
    endfunction

    function void note_sample(input logic [SAMPLE_W-1:0] s);
      logic [SAMPLE_W-1:0] clipped;
      logic [SQ_W-1:0]     sq;
      longint unsigned     edge_val;
      reading_t            r;
      clipped = (s > SAMPLE_MAX) ? SAMPLE_MAX : s;
      sq = SQ_W'(clipped) * SQ_W'(clipped);
      // Replace the oldest square and keep the sum exact.
      window_total = window_total - squares[slot] + sq;
      squares[slot] = sq;
      slot = (slot + 1) % WIN;
      r.mean = mean_now();
      r.band = '0;
      for (int k = 1; k <= BAND_COUNT; k++) begin
        edge_val = longint'(k) * longint'(step);
        if (r.band == 0 && r.mean <= edge_val) r.band = BAND_W'(k);
      end
      if (r.band == 0) r.led = '0;
      else if (r.band <= RAMP_BANDS) r.led = LED_W'((9'd1 << r.band) - 9'd1);
      else r.led = FULL_BAR;
      r.over = (r.band == 0);
      readings_due.push_back(r);
    endfunction

    function void check_reading(input reading_t got);
      reading_t want;
      if (readings_due.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOWN_ERRS)
          $display("unexpected result: mean %0d band %0d led %h over %0d",
                   got.mean, got.band, got.led, got.over);
        return;
      end
      want = readings_due.pop_front();
      if (got.mean !== want.mean || got.band !== want.band ||
          got.led !== want.led || got.over !== want.over) begin
        mismatches++;
        if (mismatches <= SHOWN_ERRS)
          $display("mismatch: expected mean %0d band %0d led %h over %0d,",
                   want.mean, want.band, want.led, want.over,
                   " got mean %0d band %0d led %h over %0d",
                   got.mean, got.band, got.led, got.over);
      end
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic [SAMPLE_W-1:0] sample;
  logic                out_valid;
  logic                out_stall;
  logic [MEAN_W-1:0]   mean_square;
  logic [BAND_W-1:0]   band;
  logic [LED_W-1:0]    led_pattern;
  logic                over_range;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [STEP_W-1:0]   level_step;

  bit          tx_idle_en = 1'b1;
  bit          rx_idle_en = 1'b1;
  bit          hold_req   = 1'b0;
  int unsigned cycles     = 0;
  level_scoreboard sb;

  mean_square_level_bargraph_top dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .sample     (sample),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .mean_square(mean_square),
    .band       (band),
    .led_pattern(led_pattern),
    .over_range (over_range),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .level_step (level_step)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("mean_square_level_bargraph_top_test NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_reading(reading_t'{mean: mean_square, band: band,
                                  led: led_pattern, over: over_range});
  end

  // Result side: random stall, plus a long hold-off counted here on request.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= rx_idle_en && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  task automatic send_sample(input logic [SAMPLE_W-1:0] v);
    while (tx_idle_en && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    sample   <= v;
    do @(posedge clk); while (in_stall);
    sb.note_sample(sample);
    @(negedge clk);
  endtask

  task automatic drain_readings();
    in_valid <= 1'b0;
    while (sb.readings_due.size() != 0) @(negedge clk);
  endtask

  // Write the band width only once the meter has returned every reading.
  task automatic write_step(input logic [STEP_W-1:0] v);
    drain_readings();
    cfg_valid  <= 1'b1;
    level_step <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_step(level_step);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Spread the band width around the current mean so every band gets hit.
  function automatic logic [STEP_W-1:0] pick_step(input logic [MEAN_W-1:0] m);
    longint unsigned s;
    int unsigned     r;
    r = $urandom_range(0, 11);
    if (r == 0) return 1;
    if (r == 1) return '1;
    if (r == 2) return '0;
    s = (longint'(m) * 8) / $urandom_range(1, 72);
    if (s == 0) s = 1;
    if (s > 20'hFFFFF) s = 20'hFFFFF;
    return STEP_W'(s);
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample(input int unsigned ceiling);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5) return SAMPLE_W'($urandom_range(1280, 2047));
    if (r < 15) return SAMPLE_W'($urandom_range(0, 2047));
    return SAMPLE_W'($urandom_range(0, ceiling));
  endfunction

  initial begin
    int unsigned ceiling;
    sb = new();
    rst        = 1'b1;
    in_valid   = 1'b0;
    sample     = '0;
    cfg_valid  = 1'b0;
    level_step = '0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // Reset band width, then zero width with a zero and a nonzero mean.
    send_sample(11'd0);
    send_sample(11'd0);
    write_step(20'd0);
    send_sample(11'd0);
    send_sample(11'd2047);
    // Narrowest band; samples across the range, including saturation.
    write_step(20'd1);
    send_sample(11'd1279);
    send_sample(11'd1280);
    send_sample(11'd1);
    send_sample(11'h555);
    send_sample(11'h2AA);
    send_sample(11'd1024);
    // Widest band.
    write_step(20'hFFFFF);
    send_sample(11'd2047);
    send_sample(11'd2047);
    send_sample(11'd255);
    send_sample(11'd512);
    // Width well below the current mean, so the readings are over range.
    write_step(20'd200);
    send_sample(11'd1279);
    send_sample(11'd1279);
    send_sample(11'd0);
    send_sample(11'd100);

    for (int p = 0; p < PHASES; p++) begin
      write_step(pick_step(sb.mean_now()));
      tx_idle_en = (p != 3) && (p != 6);
      rx_idle_en = (p != 3);
      // Hold the result side off while requests keep coming, to back up the pipe.
      if (p == 6) hold_req = 1'b1;
      ceiling = $urandom_range(0, 2047);
      repeat (PHASE_ITEMS) send_sample(pick_sample(ceiling));
    end

    drain_readings();
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.readings_due.size() == 0) begin
      $display("mean_square_level_bargraph_top_test OK");
    end else begin
      $display("mean_square_level_bargraph_top_test NOT OK");
    end
    $finish;
  end

endmodule
